/* rtl/pcdq_pkg.sv */
// ----------------------------------------------------------------------------
// pcdq_pkg: shared types and constants of the per-channel dequantizer
// Register indexes, input type codes, and the front-to-back item record.
// ----------------------------------------------------------------------------
package pcdq_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int CH_W = 8;

  typedef enum logic [2:0] {
    REG_INPUT_TYPE  = 3'd0,
    REG_OUTPUT_HALF = 3'd1,
    REG_CHAN_COUNT  = 3'd2,
    REG_BLK_LEN     = 3'd3,
    REG_OUTER_COUNT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    TYPE_INT8   = 3'd0,
    TYPE_UINT8  = 3'd1,
    TYPE_INT16  = 3'd2,
    TYPE_UINT16 = 3'd3,
    TYPE_INT32  = 3'd4,
    TYPE_INT4   = 3'd5,
    TYPE_UINT4  = 3'd6,
    TYPE_RSVD   = 3'd7
  } in_type_t;

  // One classified data element, as handed from the front to the back.
  typedef struct packed {
    logic signed [33:0] diff;
    logic [CH_W-1:0]    channel;
    logic               last;
    logic               half;
  } item_t;

endpackage

/* rtl/per_channel_dequantizer.sv */
// Path: an accepted data element passes table read, queue, float convert, multiply,
//   float32 round and fp16 pack on its way to its result; loads give no result.
// Throughput: one element or load per cycle while in_stall is low; the 2-entry queue
//   and pipeline registers stall independently.
// Reset (rst_n, synchronous): clears counters, pipeline valids and registers;
//   the channel table is undefined until loaded.
// ----------------------------------------------------------------------------
// per_channel_dequantizer: per-channel linear dequantizer, top level
// Front classifies and counts, queue decouples, back does float arithmetic.
// ----------------------------------------------------------------------------
module per_channel_dequantizer (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [7:0]         in_load_channel,
  input  logic [31:0]        in_scale_bits,
  input  logic signed [16:0] in_zero_offset,
  input  logic [31:0]        in_raw_value,
  // result transaction
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_result_bits,
  output logic [7:0]         out_channel,
  output logic               out_last_element,
  // register port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import pcdq_pkg::*;

  logic [2:0]  input_type_r;
  logic        output_half_r;
  logic [8:0]  channel_count_r;
  logic [31:0] blk_len_r, outer_count_r;
  logic        wr_en;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx  = cfg_paddr[4:2];

  // Write a register on the access phase; unknown addresses are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_type_r    <= 3'd0;
      output_half_r   <= 1'b0;
      channel_count_r <= 9'd1;
      blk_len_r       <= 32'd1;
      outer_count_r   <= 32'd1;
    end else if (wr_en) begin
      case (reg_idx_t'(ridx))
        REG_INPUT_TYPE:  input_type_r    <= cfg_pwdata[2:0];
        REG_OUTPUT_HALF: output_half_r   <= cfg_pwdata[0];
        REG_CHAN_COUNT:  channel_count_r <= cfg_pwdata[8:0];
        REG_BLK_LEN:     blk_len_r       <= cfg_pwdata;
        REG_OUTER_COUNT: outer_count_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(ridx))
      REG_INPUT_TYPE:  cfg_prdata = {29'd0, input_type_r};
      REG_OUTPUT_HALF: cfg_prdata = {31'd0, output_half_r};
      REG_CHAN_COUNT:  cfg_prdata = {23'd0, channel_count_r};
      REG_BLK_LEN:     cfg_prdata = blk_len_r;
      REG_OUTER_COUNT: cfg_prdata = outer_count_r;
      default:         cfg_prdata = 32'd0;
    endcase
  end

  logic        f_valid, f_stall, q_valid, q_stall;
  item_t       f_item, q_item;
  logic [31:0] f_scale, q_scale;

  // Front: table writes, counters, operand fetch.
  pcdq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_load_channel,
    .in_scale_bits, .in_zero_offset, .in_raw_value,
    .input_type(input_type_r), .output_half(output_half_r),
    .channel_count(channel_count_r), .blk_len(blk_len_r),
    .outer_count(outer_count_r),
    .item_valid(f_valid), .item(f_item), .item_scale(f_scale), .item_stall(f_stall)
  );

  // Hold classified elements while the back end stalls.
  pcdq_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_item(f_item), .wr_scale(f_scale),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_item(q_item), .rd_scale(q_scale)
  );

  // Back: convert, multiply, round, optional fp16 pack.
  pcdq_back u_back (
    .clk, .rst_n,
    .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item), .in_scale(q_scale),
    .out_valid, .out_stall, .out_result_bits, .out_channel, .out_last_element
  );

  a_rst_cfg: assert property (@(posedge clk) !rst_n |=> channel_count_r == 9'd1)
    else $error("channel count reset wrong");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel))
    else $error("result lost under stall");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && ridx == REG_BLK_LEN |=> blk_len_r == $past(cfg_pwdata))
    else $error("block length write lost");
endmodule

/* rtl/pcdq_front.sv */
// ----------------------------------------------------------------------------
// pcdq_front: accept loads and data elements
// Writes the channel table, steps position counters, forms x minus zero offset.
// ----------------------------------------------------------------------------
module pcdq_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [7:0]            in_load_channel,
  input  logic [31:0]           in_scale_bits,
  input  logic signed [16:0]    in_zero_offset,
  input  logic [31:0]           in_raw_value,
  input  logic [2:0]            input_type,
  input  logic                  output_half,
  input  logic [8:0]            channel_count,
  input  logic [31:0]           blk_len,
  input  logic [31:0]           outer_count,
  output logic                  item_valid,
  output pcdq_pkg::item_t       item,
  output logic [31:0]           item_scale,
  input  logic                  item_stall
);
  import pcdq_pkg::*;

  logic [31:0]        scale_mem [MAX_CHANNELS];
  logic signed [16:0] zero_mem  [MAX_CHANNELS];

  logic [CH_W-1:0] ch_r;
  logic [31:0]     blk_r, out_r;
  logic            vld_r;
  logic [31:0]     scale_r;
  logic signed [16:0] zero_r;
  logic signed [32:0] x_r;
  logic [CH_W-1:0] och_r;
  logic            last_r, half_r;

  logic take, take_data, advance;
  logic [8:0]  chans;
  logic [31:0] bs, oc;
  logic end_blk, end_ch, end_out;
  logic signed [32:0] x_ext;

  assign advance   = !vld_r || !item_stall;
  assign in_stall  = !advance;
  assign take      = in_valid && advance;
  assign take_data = take && in_mode;

  assign chans = (channel_count == 9'd0) ? 9'd1 :
                 (channel_count > 9'(MAX_CHANNELS)) ? 9'(MAX_CHANNELS) : channel_count;
  assign bs = (blk_len == 32'd0) ? 32'd1 : blk_len;
  assign oc = (outer_count == 32'd0) ? 32'd1 : outer_count;
  assign end_blk = ({1'b0, blk_r} + 33'd1) >= {1'b0, bs};
  assign end_ch  = ({1'b0, ch_r} + 9'd1) >= chans;
  assign end_out = ({1'b0, out_r} + 33'd1) >= {1'b0, oc};

  always_comb begin
    case (in_type_t'(input_type))
      TYPE_INT8:   x_ext = 33'(signed'(in_raw_value[7:0]));
      TYPE_UINT8:  x_ext = {25'd0, in_raw_value[7:0]};
      TYPE_INT16:  x_ext = 33'(signed'(in_raw_value[15:0]));
      TYPE_UINT16: x_ext = {17'd0, in_raw_value[15:0]};
      TYPE_INT4:   x_ext = 33'(signed'(in_raw_value[3:0]));
      TYPE_UINT4:  x_ext = {29'd0, in_raw_value[3:0]};
      default:     x_ext = 33'(signed'(in_raw_value));
    endcase
  end

  // Table write and registered table read share one clocked block.
  always_ff @(posedge clk) begin
    if (take && !in_mode) begin
      scale_mem[in_load_channel] <= in_scale_bits;
      zero_mem[in_load_channel]  <= in_zero_offset;
    end
    if (take_data) begin
      scale_r <= scale_mem[ch_r];
      zero_r  <= zero_mem[ch_r];
      x_r     <= x_ext;
      och_r   <= ch_r;
      last_r  <= end_blk && end_ch && end_out;
      half_r  <= output_half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ch_r  <= '0;
      blk_r <= '0;
      out_r <= '0;
    end else begin
      if (advance) vld_r <= take_data;
      if (take_data) begin
        if (end_blk) begin
          blk_r <= '0;
          if (end_ch) begin
            ch_r  <= '0;
            out_r <= end_out ? 32'd0 : out_r + 32'd1;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end else begin
          blk_r <= blk_r + 32'd1;
        end
      end
    end
  end

  assign item_valid   = vld_r;
  assign item_scale   = scale_r;
  assign item.diff    = 34'(x_r) - 34'(zero_r);
  assign item.channel = och_r;
  assign item.last    = last_r;
  assign item.half    = half_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && item_stall |=> vld_r && $stable(och_r))
    else $error("front item dropped under stall");
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    take_data && end_blk && !end_ch |=> ch_r == $past(ch_r) + 1'b1)
    else $error("channel step wrong");
  a_last_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    take_data && end_blk && end_ch && end_out |=> ch_r == '0 && out_r == '0 && blk_r == '0)
    else $error("tensor wrap wrong");
endmodule

/* rtl/pcdq_queue.sv */
// ----------------------------------------------------------------------------
// pcdq_queue: two-entry queue between front and back
// Decouples the stall of the back from the front.
// ----------------------------------------------------------------------------
module pcdq_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  pcdq_pkg::item_t wr_item,
  input  logic [31:0]     wr_scale,
  output logic            rd_valid,
  input  logic            rd_stall,
  output pcdq_pkg::item_t rd_item,
  output logic [31:0]     rd_scale
);
  import pcdq_pkg::*;

  item_t       item_q  [2];
  logic [31:0] scale_q [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;
  assign rd_item  = item_q[rp_r];
  assign rd_scale = scale_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      item_q[wp_r]  <= wr_item;
      scale_q[wp_r] <= wr_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers out of step");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid && rd_stall |=> rd_valid)
    else $error("queue head lost");
endmodule

/* rtl/pcdq_back.sv */
// ----------------------------------------------------------------------------
// pcdq_back: float conversion and scale multiply
// Stage 1: diff to float32. Stage 2: 24x24 multiply. Stage 3: round float32.
// Stage 4: optional fp16 pack.
// ----------------------------------------------------------------------------
module pcdq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pcdq_pkg::item_t in_item,
  input  logic [31:0]     in_scale,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_result_bits,
  output logic [7:0]      out_channel,
  output logic            out_last_element
);
  import pcdq_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  // stage 1: int to float32
  logic [33:0] mag;
  logic [5:0]  lz;
  logic        s0;
  logic [31:0] fx;
  always_comb begin
    logic [33:0] nrm;
    logic        rnd;
    logic [7:0]  ex;
    s0  = in_item.diff[33];
    mag = s0 ? 34'(-in_item.diff) : 34'(in_item.diff);
    lz  = 6'd0;
    for (int i = 0; i < 34; i++) if (mag[i]) lz = 6'(33 - i);
    nrm = mag << lz;
    // value = nrm[33:10]. , guard nrm[9], sticky nrm[8:0]
    rnd = nrm[9] && ((|nrm[8:0]) || nrm[10]);
    ex  = 8'(8'd160 - {2'd0, lz});
    fx  = {s0, ex, nrm[32:10]} + {31'd0, rnd};
    if (mag == 34'd0) fx = {s0, 31'd0};
  end

  logic [31:0] fx_r, sc_r;
  item_t       it1_r;
  assign adv4 = !v4_r || !out_stall;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) if (adv1 && in_valid) begin
    fx_r <= fx; sc_r <= in_scale; it1_r <= in_item;
  end

  // stage 2: special cases and multiply
  logic sa_nan, sb_nan, s_inf, s_zero, sp_sign;
  logic [31:0] spec;
  logic        is_spec;
  logic [23:0] ma, mb;
  logic signed [10:0] ee;
  always_comb begin
    logic az, bz;
    az = fx_r[30:0] == 31'd0;
    bz = sc_r[30:0] == 31'd0;
    sp_sign = fx_r[31] ^ sc_r[31];
    sa_nan = (fx_r[30:23] == 8'hFF) && (fx_r[22:0] != 23'd0);
    sb_nan = (sc_r[30:23] == 8'hFF) && (sc_r[22:0] != 23'd0);
    s_inf  = (fx_r[30:23] == 8'hFF) || (sc_r[30:23] == 8'hFF);
    s_zero = az || bz;
    is_spec = 1'b1;
    if (sa_nan)      spec = fx_r | 32'h0040_0000;
    else if (sb_nan) spec = sc_r | 32'h0040_0000;
    else if (s_inf)  spec = s_zero ? 32'h7FC0_0000 : {sp_sign, 31'h7F80_0000};
    else if (s_zero) spec = {sp_sign, 31'd0};
    else begin
      spec = 32'd0; is_spec = 1'b0;
    end
    ma = (fx_r[30:23] == 8'd0) ? {1'b0, fx_r[22:0]} : {1'b1, fx_r[22:0]};
    mb = (sc_r[30:23] == 8'd0) ? {1'b0, sc_r[22:0]} : {1'b1, sc_r[22:0]};
    ee = ((fx_r[30:23] == 8'd0) ? 11'sd1 : 11'(signed'({3'b0, fx_r[30:23]})))
       + ((sc_r[30:23] == 8'd0) ? 11'sd1 : 11'(signed'({3'b0, sc_r[30:23]})))
       - 11'sd300;
  end

  logic [47:0] p_r;
  logic signed [10:0] e_r;
  logic sg_r, spf_r;
  logic [31:0] sp_r;
  item_t it2_r;
  always_ff @(posedge clk) if (adv2 && v1_r) begin
    p_r <= ma * mb; e_r <= ee; sg_r <= sp_sign;
    spf_r <= is_spec; sp_r <= spec; it2_r <= it1_r;
  end

  // stage 3: normalize and round to float32
  logic [31:0] prod, res;
  always_comb begin
    logic [5:0]  lzp;
    logic [47:0] n;
    logic signed [11:0] bexp;   // biased exponent of leading bit at n[47]
    logic [11:0] sh;
    logic [71:0] w;
    logic [24:0] q;
    logic        g, st;
    lzp = 6'd0;
    for (int i = 0; i < 48; i++) if (p_r[i]) lzp = 6'(47 - i);
    n = p_r << lzp;
    // value = n * 2^(e_r - lzp); leading bit weight 2^(e_r-lzp+47)
    bexp = 12'(e_r) + 12'sd47 + 12'sd127 - 12'(signed'({1'b0, lzp}));
    sh = (bexp < 12'sd1) ? 12'(12'sd1 - bexp) : 12'd0;
    w = {n, 24'd0} >> ((sh > 12'd30) ? 12'd30 : sh);
    // keep 24 bits: w[71:48], guard w[47], sticky rest
    g  = w[47];
    st = |w[46:0];
    q  = {1'b0, w[71:48]} + {24'd0, g && (st || w[48])};
    if (bexp < 12'sd1) begin
      // subnormal range; q holds fraction bits with implicit zero exponent
      prod = {sg_r, 31'(q)};
    end else if (q[24]) begin
      prod = (bexp + 12'sd1 >= 12'sd255) ? {sg_r, 31'h7F80_0000}
                                         : {sg_r, 8'(bexp + 12'sd1), q[23:1]};
    end else begin
      prod = (bexp >= 12'sd255) ? {sg_r, 31'h7F80_0000}
                                : {sg_r, 8'(bexp), q[22:0]};
    end
    if (spf_r) prod = sp_r;
  end

  logic [31:0] pr_r;
  item_t       it3_r;
  always_ff @(posedge clk) if (adv3 && v2_r) begin
    pr_r <= prod; it3_r <= it2_r;
  end

  // stage 4: narrow the rounded float32 to fp16 when asked
  logic [15:0] hf;
  always_comb begin
    logic [7:0]  ex;
    logic [23:0] m;
    logic signed [9:0] hb;
    logic [5:0]  sh;
    logic [47:0] w;
    logic [11:0] q;
    ex = pr_r[30:23];
    m  = (ex == 8'd0) ? {1'b0, pr_r[22:0]} : {1'b1, pr_r[22:0]};
    hb = 10'(signed'({2'b0, ex})) - 10'sd112;
    sh = (hb < 10'sd1) ? ((10'sd1 - hb > 10'sd30) ? 6'd30 : 6'(10'sd1 - hb)) : 6'd0;
    w  = {m, 24'd0} >> sh;
    // keep 11 bits w[47:37], guard w[36], sticky w[35:0]
    q  = {1'b0, w[47:37]} + {11'd0, w[36] && ((|w[35:0]) || w[37])};
    if (ex == 8'hFF)
      hf = (pr_r[22:0] != 23'd0) ? {pr_r[31], 5'h1F, 1'b1, pr_r[21:13]}
                                 : {pr_r[31], 15'h7C00};
    else if (ex == 8'd0 || hb < 10'sd1)
      hf = {pr_r[31], 15'(q)};
    else if (q[11])
      hf = (hb + 10'sd1 >= 10'sd31) ? {pr_r[31], 15'h7C00}
                                    : {pr_r[31], 5'(hb + 10'sd1), q[10:1]};
    else
      hf = (hb >= 10'sd31) ? {pr_r[31], 15'h7C00} : {pr_r[31], 5'(hb), q[9:0]};
  end
  assign res = it3_r.half ? {16'd0, hf} : pr_r;

  logic [31:0] r_r;
  logic [7:0]  c_r;
  logic        l_r;
  always_ff @(posedge clk) if (adv4 && v3_r) begin
    r_r <= res; c_r <= it3_r.channel; l_r <= it3_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  assign out_valid        = v4_r;
  assign out_result_bits  = r_r;
  assign out_channel      = c_r;
  assign out_last_element = l_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && out_stall |=> v4_r && $stable(r_r))
    else $error("result changed under stall");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv3 |=> v2_r)
    else $error("stage two lost");
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && adv4 && it3_r.half |=> r_r[31:16] == 16'd0)
    else $error("fp16 upper half set");
endmodule
